// ===== design/vslc_pkg.sv =====
// ----------------------------------------------------------------------------
// vslc_pkg: shared types and constants
// Codes, state types and the job record passed from the front to the back end.
// ----------------------------------------------------------------------------
package vslc_pkg;

    localparam logic [7:0] LEN_BYTE = 8'h0F;
    localparam logic [7:0] CODE_R   = 8'h72;
    localparam logic [7:0] CODE_V   = 8'h76;
    localparam logic [7:0] CODE_S   = 8'h73;
    localparam logic [7:0] CODE_F   = 8'h46;
    localparam logic [7:0] CODE_P   = 8'h50;
    localparam logic [7:0] CODE_I   = 8'h49;

    localparam logic [30:0] QUERY_DEFAULT   = 31'd1000000;
    localparam logic [30:0] RECHECK_DEFAULT = 31'd200000;
    localparam logic [30:0] SETTLE_DEFAULT  = 31'd300000;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;

    localparam logic [3:0] LAST_BEAT = 4'd15;

    typedef enum logic [1:0] {
        CMD_RX     = 2'd0,
        CMD_POLL   = 2'd1,
        CMD_COMMIT = 2'd2,
        CMD_PIT    = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        PH_LEN  = 2'd0,
        PH_CODE = 2'd1,
        PH_DATA = 2'd2
    } parse_t;

    typedef enum logic [1:0] {
        LINK_OFF   = 2'd0,
        LINK_ON    = 2'd1,
        LINK_SET   = 2'd2,
        LINK_CHECK = 2'd3
    } link_t;

    typedef enum logic [1:0] {
        PEND_NONE = 2'd0,
        PEND_R    = 2'd1,
        PEND_V    = 2'd2
    } pend_t;

    typedef enum logic [2:0] {
        REG_TARGET_FREQ  = 3'd0,
        REG_TARGET_POWER = 3'd1,
        REG_QUERY_IVL    = 3'd2,
        REG_RECHECK_IVL  = 3'd3,
        REG_SETTLE_DLY   = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic [15:0] target_freq;
        logic [15:0] target_power;
        logic [30:0] query_interval_us;
        logic [30:0] recheck_interval_us;
        logic [30:0] settle_delay_us;
    } cfg_t;

    typedef struct packed {
        logic        has_frame;
        logic [7:0]  code;
        logic [15:0] param;
        logic [1:0]  link_state;
        logic        accepted;
        logic [15:0] cur_freq;
        logic [15:0] cur_config_power;
        logic [15:0] cur_power;
        logic [7:0]  pit_state;
        logic [15:0] freq_min;
        logic [15:0] freq_max;
        logic [15:0] power_max;
    } job_t;

endpackage

// ===== design/vslc_front.sv =====
// ----------------------------------------------------------------------------
// vslc_front: command front end
// Runs the deframer and link state machine, one item per cycle while take is high, and emits a job.
// ----------------------------------------------------------------------------
module vslc_front
    import vslc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        take,
    input  logic [1:0]  command,
    input  logic [7:0]  rx_byte,
    input  logic [31:0] now_us,
    input  logic        pit_on,
    input  cfg_t        cfg,
    output job_t        job
);

    parse_t      phase_reg, phase_next;
    logic [4:0]  pos_reg, pos_next;
    logic [7:0]  sum_reg, sum_next;
    link_t       link_reg, link_next;
    pend_t       pend_reg, pend_next;
    logic [31:0] lqt_reg, lqt_next;
    logic [15:0] fmin_reg, fmin_next, fmax_reg, fmax_next, pmax_reg, pmax_next;
    logic [15:0] freq_reg, freq_next, cpow_reg, cpow_next, pow_reg, pow_next;
    logic [7:0]  pit_reg, pit_next;
    logic [7:0]  store_reg [16];
    logic        store_we;

    logic [3:0]  idx;
    logic [15:0] w2;
    logic        ok;
    link_t       link_tmp;
    logic [30:0] ivl;
    logic [31:0] delta;
    logic        elapsed;

    assign idx   = pos_reg[3:0];
    assign w2    = {store_reg[3], store_reg[2]};
    // The final byte (index 15) must be zero; the running sum already holds bytes 1 to 13.
    assign ok    = (store_reg[14] == sum_reg) && (rx_byte == 8'h00);
    assign delta = now_us - lqt_reg;

    always_comb
    begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        sum_next   = sum_reg;
        link_next  = link_reg;
        pend_next  = pend_reg;
        lqt_next   = lqt_reg;
        fmin_next  = fmin_reg;
        fmax_next  = fmax_reg;
        pmax_next  = pmax_reg;
        freq_next  = freq_reg;
        cpow_next  = cpow_reg;
        pow_next   = pow_reg;
        pit_next   = pit_reg;
        store_we   = 1'b0;
        link_tmp   = link_reg;
        ivl        = cfg.query_interval_us;
        elapsed    = 1'b0;
        job        = '0;
        case (cmd_t'(command))
            CMD_RX:
            begin
                store_we = 1'b1;
                pos_next = pos_reg + 5'd1;
                if (idx == 4'd0)
                    sum_next = 8'h00;
                else if (idx inside {[4'd1:4'd13]})
                    sum_next = sum_reg + rx_byte;
                case (phase_reg)
                    PH_LEN:
                    begin
                        if (rx_byte == LEN_BYTE)
                            phase_next = PH_CODE;
                        else
                            pos_next = 5'd0;
                    end
                    PH_CODE:
                    begin
                        if (rx_byte == CODE_R || rx_byte == CODE_V || rx_byte == CODE_S)
                            phase_next = PH_DATA;
                        else
                        begin
                            phase_next = PH_LEN;
                            pos_next   = 5'd0;
                        end
                    end
                    PH_DATA:
                    begin
                        if (pos_next[4])
                        begin
                            phase_next = PH_LEN;
                            pos_next   = 5'd0;
                            if (ok && w2 != 16'd0)
                            begin
                                if (store_reg[1] == CODE_R)
                                begin
                                    fmin_next = w2;
                                    fmax_next = {store_reg[5], store_reg[4]};
                                    pmax_next = {store_reg[7], store_reg[6]};
                                    pend_next = PEND_R;
                                end
                                else if (store_reg[1] == CODE_V)
                                begin
                                    freq_next = w2;
                                    cpow_next = {store_reg[5], store_reg[4]};
                                    pit_next  = store_reg[7];
                                    pow_next  = {store_reg[9], store_reg[8]};
                                    pend_next = PEND_V;
                                end
                            end
                        end
                    end
                    default:
                    begin
                        phase_next = PH_LEN;
                        pos_next   = 5'd0;
                    end
                endcase
            end
            CMD_POLL:
            begin
                if (pend_reg == PEND_R && link_reg == LINK_OFF)
                    link_tmp = LINK_ON;
                else if (pend_reg == PEND_V && link_reg == LINK_CHECK)
                    link_tmp = LINK_SET;
                pend_next = PEND_NONE;
                link_next = link_tmp;
                if (link_tmp == LINK_CHECK)
                    ivl = cfg.recheck_interval_us;
                elapsed = !delta[31] && (delta[30:0] > ivl);
                case (link_tmp)
                    LINK_SET:
                    begin
                        if (cfg.target_freq != freq_reg)
                        begin
                            job.has_frame = 1'b1;
                            job.code      = CODE_F;
                            job.param     = cfg.target_freq;
                        end
                        else if (cfg.target_power != cpow_reg)
                        begin
                            job.has_frame = 1'b1;
                            job.code      = CODE_P;
                            job.param     = cfg.target_power;
                        end
                        if (job.has_frame)
                        begin
                            link_next = LINK_CHECK;
                            lqt_next  = now_us + {1'b0, cfg.settle_delay_us};
                        end
                        else
                            link_next = LINK_ON;
                    end
                    default:
                    begin
                        if (elapsed)
                        begin
                            job.has_frame = 1'b1;
                            job.code      = (link_tmp == LINK_OFF) ? CODE_R : CODE_V;
                            lqt_next      = now_us;
                            phase_next    = PH_LEN;
                            pos_next      = 5'd0;
                        end
                    end
                endcase
            end
            CMD_COMMIT:
            begin
                if (link_reg == LINK_ON)
                begin
                    link_next    = LINK_SET;
                    job.accepted = 1'b1;
                end
            end
            default:
            begin
                job.has_frame = 1'b1;
                job.code      = CODE_I;
                job.param     = {15'd0, !pit_on};
            end
        endcase
        job.link_state       = link_next;
        job.cur_freq         = freq_next;
        job.cur_config_power = cpow_next;
        job.cur_power        = pow_next;
        job.pit_state        = pit_next;
        job.freq_min         = fmin_next;
        job.freq_max         = fmax_next;
        job.power_max        = pmax_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_LEN;
            pos_reg   <= 5'd0;
            sum_reg   <= 8'h00;
            link_reg  <= LINK_OFF;
            pend_reg  <= PEND_NONE;
            lqt_reg   <= 32'd0;
            fmin_reg  <= 16'd0;
            fmax_reg  <= 16'd0;
            pmax_reg  <= 16'd0;
            freq_reg  <= 16'd0;
            cpow_reg  <= 16'd0;
            pow_reg   <= 16'd0;
            pit_reg   <= 8'h00;
        end
        else if (take)
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            sum_reg   <= sum_next;
            link_reg  <= link_next;
            pend_reg  <= pend_next;
            lqt_reg   <= lqt_next;
            fmin_reg  <= fmin_next;
            fmax_reg  <= fmax_next;
            pmax_reg  <= pmax_next;
            freq_reg  <= freq_next;
            cpow_reg  <= cpow_next;
            pow_reg   <= pow_next;
            pit_reg   <= pit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && store_we)
            store_reg[idx] <= rx_byte;
    end

endmodule

// ===== design/vslc_fifo.sv =====
// ----------------------------------------------------------------------------
// vslc_fifo: job queue
// Small first-in first-out buffer that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module vslc_fifo
    import vslc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t wr_job,
    output logic full,
    input  logic pop,
    output logic empty,
    output job_t rd_job
);

    job_t                 mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wp_reg, rp_reg;
    logic [FIFO_AW:0]     cnt_reg;

    assign full   = (cnt_reg == (FIFO_AW+1)'(FIFO_DEPTH));
    assign empty  = (cnt_reg == '0);
    assign rd_job = mem[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wp_reg] <= wr_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wp_reg <= wp_reg + 1'b1;
            if (pop)
                rp_reg <= rp_reg + 1'b1;
            if (push && !pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

endmodule

// ===== design/vslc_back.sv =====
// ----------------------------------------------------------------------------
// vslc_back: result sequencer
// Turns each job into one status beat or a sixteen-beat request frame.
// ----------------------------------------------------------------------------
module vslc_back
    import vslc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_empty,
    input  job_t        q_job,
    output logic        q_pop,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        has_tx,
    output logic [7:0]  tx_byte,
    output logic        tx_last,
    output job_t        cur
);

    job_t       job_reg;
    logic       valid_reg;
    logic [3:0] beat_reg;
    logic [7:0] csum;

    assign csum    = job_reg.code + job_reg.param[7:0] + job_reg.param[15:8];
    assign tx_last = !job_reg.has_frame || (beat_reg == LAST_BEAT);
    assign has_tx  = job_reg.has_frame;
    assign out_valid = valid_reg;
    assign cur     = job_reg;
    assign q_pop   = !q_empty && (!valid_reg || (out_ready && tx_last));

    always_comb
    begin
        tx_byte = 8'h00;
        if (job_reg.has_frame)
        begin
            case (beat_reg)
                4'd0:    tx_byte = LEN_BYTE;
                4'd1:    tx_byte = job_reg.code;
                4'd2:    tx_byte = job_reg.param[7:0];
                4'd3:    tx_byte = job_reg.param[15:8];
                4'd14:   tx_byte = csum;
                default: tx_byte = 8'h00;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            job_reg <= q_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            beat_reg  <= 4'd0;
        end
        else if (q_pop)
        begin
            valid_reg <= 1'b1;
            beat_reg  <= 4'd0;
        end
        else if (valid_reg && out_ready)
        begin
            if (tx_last)
                valid_reg <= 1'b0;
            else
                beat_reg <= beat_reg + 4'd1;
        end
    end

endmodule

// ===== design/vtx_serial_link_controller.sv =====
// ----------------------------------------------------------------------------
// vtx_serial_link_controller: serial video-transmitter link controller
// Deframes replies, tracks link state and sends 16-byte request frames.
// ----------------------------------------------------------------------------
// Path: an accepted item is written into the job queue and then loaded into the back
// end's job register, which drives its result beats; a busy output holds it queued.
// Throughput: one item per cycle while the job queue has room; an item that sends a
// frame occupies the output for sixteen beats, which sets the rate during frames.
// Reset: rst_n clears the link, deframer, status and range registers and the queue,
// and loads the interval registers with their defaults.
module vtx_serial_link_controller
    import vslc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  command,
    input  logic [7:0]  rx_byte,
    input  logic [31:0] now_us,
    input  logic        pit_on,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        has_tx,
    output logic [7:0]  tx_byte,
    output logic        tx_last,
    output logic [1:0]  link_state,
    output logic        commit_accepted,
    output logic [15:0] cur_freq,
    output logic [15:0] cur_config_power,
    output logic [15:0] cur_power,
    output logic [7:0]  pit_state,
    output logic [15:0] freq_min,
    output logic [15:0] freq_max,
    output logic [15:0] power_max,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // Configuration registers. The register index is the word address paddr[4:2].
    cfg_t       cfg_reg;
    logic       wr_en;
    reg_idx_t   ridx;

    job_t       fjob;
    job_t       qjob;
    job_t       cur;
    logic       q_full;
    logic       q_empty;
    logic       q_pop;
    logic       take;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign ridx   = reg_idx_t'(paddr[4:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.target_freq         <= 16'd0;
            cfg_reg.target_power        <= 16'd0;
            cfg_reg.query_interval_us   <= QUERY_DEFAULT;
            cfg_reg.recheck_interval_us <= RECHECK_DEFAULT;
            cfg_reg.settle_delay_us     <= SETTLE_DEFAULT;
        end
        else if (wr_en)
        begin
            case (ridx)
                REG_TARGET_FREQ:  cfg_reg.target_freq         <= pwdata[15:0];
                REG_TARGET_POWER: cfg_reg.target_power        <= pwdata[15:0];
                REG_QUERY_IVL:    cfg_reg.query_interval_us   <= pwdata[30:0];
                REG_RECHECK_IVL:  cfg_reg.recheck_interval_us <= pwdata[30:0];
                REG_SETTLE_DLY:   cfg_reg.settle_delay_us     <= pwdata[30:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (ridx)
            REG_TARGET_FREQ:  prdata = {16'd0, cfg_reg.target_freq};
            REG_TARGET_POWER: prdata = {16'd0, cfg_reg.target_power};
            REG_QUERY_IVL:    prdata = {1'b0, cfg_reg.query_interval_us};
            REG_RECHECK_IVL:  prdata = {1'b0, cfg_reg.recheck_interval_us};
            REG_SETTLE_DLY:   prdata = {1'b0, cfg_reg.settle_delay_us};
            default:          prdata = 32'd0;
        endcase
    end

    // The front end takes a beat whenever the queue has room, so a finished
    // result waiting at the output holds up the input side only once the queue is full.
    assign in_ready = !q_full;
    assign take     = in_valid && in_ready;

    vslc_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .take    (take),
        .command (command),
        .rx_byte (rx_byte),
        .now_us  (now_us),
        .pit_on  (pit_on),
        .cfg     (cfg_reg),
        .job     (fjob)
    );

    vslc_fifo u_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (take),
        .wr_job (fjob),
        .full   (q_full),
        .pop    (q_pop),
        .empty  (q_empty),
        .rd_job (qjob)
    );

    vslc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_job     (qjob),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .has_tx    (has_tx),
        .tx_byte   (tx_byte),
        .tx_last   (tx_last),
        .cur       (cur)
    );

    // Status fields are the snapshot taken when the item was processed.
    assign link_state       = cur.link_state;
    assign commit_accepted  = cur.accepted;
    assign cur_freq         = cur.cur_freq;
    assign cur_config_power = cur.cur_config_power;
    assign cur_power        = cur.cur_power;
    assign pit_state        = cur.pit_state;
    assign freq_min         = cur.freq_min;
    assign freq_max         = cur.freq_max;
    assign power_max        = cur.power_max;

endmodule

// ===== design/vslc_checker.sv =====
// ----------------------------------------------------------------------------
// vslc_checker: port-level checks
// Watches the top-level result channel for beats that break the framing rules and checks that pready stays high.
// ----------------------------------------------------------------------------
module vslc_checker
    import vslc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic       has_tx,
    input  logic [7:0] tx_byte,
    input  logic       tx_last,
    input  logic       commit_accepted,
    input  logic       pready
);

    // A status-only beat is a single, closing beat with an empty byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !has_tx |-> tx_last && tx_byte == 8'h00)
        else $error("status beat not closing or not empty");

    // The closing beat of a frame carries the zero trailer byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && has_tx && tx_last |-> tx_byte == 8'h00)
        else $error("frame trailer byte not zero");

    // A commit is never reported on a frame beat.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && has_tx |-> !commit_accepted)
        else $error("commit flagged on frame beat");

    // A frame beat that is taken and not last is followed by another frame beat.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && has_tx && !tx_last |=> out_valid && has_tx)
        else $error("frame cut short");

    assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready low");

endmodule

bind vtx_serial_link_controller vslc_checker u_vslc_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .has_tx          (has_tx),
    .tx_byte         (tx_byte),
    .tx_last         (tx_last),
    .commit_accepted (commit_accepted),
    .pready          (pready)
);

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: link controller testbench
// Drives received bytes, polls, commits and pit requests through the input
// channel, predicts every result beat from a behavioral model of the link
// and deframer, and compares each beat field by field in a checker process.
// ----------------------------------------------------------------------------
module tb_top;
    import vslc_pkg::*;

    localparam int CYCLE_LIMIT = 1500000;
    localparam int HOLD_CYCLES = 300;

    // One expected result beat.
    typedef struct packed {
        logic        has_tx;
        logic [7:0]  tx_byte;
        logic        tx_last;
        logic [1:0]  link_state;
        logic        commit_accepted;
        logic [15:0] cur_freq;
        logic [15:0] cur_config_power;
        logic [15:0] cur_power;
        logic [7:0]  pit_state;
        logic [15:0] freq_min;
        logic [15:0] freq_max;
        logic [15:0] power_max;
    } beat_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  command;
    logic [7:0]  rx_byte;
    logic [31:0] now_us;
    logic        pit_on;
    logic        out_valid;
    logic        out_ready;
    logic        has_tx;
    logic [7:0]  tx_byte;
    logic        tx_last;
    logic [1:0]  link_state;
    logic        commit_accepted;
    logic [15:0] cur_freq;
    logic [15:0] cur_config_power;
    logic [15:0] cur_power;
    logic [7:0]  pit_state;
    logic [15:0] freq_min;
    logic [15:0] freq_max;
    logic [15:0] power_max;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // Predictor state: a private copy of the block's configuration and state.
    logic [15:0] m_target_freq;
    logic [15:0] m_target_power;
    logic [30:0] m_query_ivl;
    logic [30:0] m_recheck_ivl;
    logic [30:0] m_settle_dly;
    parse_t      m_parse;
    logic [4:0]  m_pos;
    logic [7:0]  m_frame [16];
    link_t       m_link;
    pend_t       m_pend;
    logic [31:0] m_last_query;
    logic [15:0] m_range [3];
    logic [15:0] m_status [3];
    logic [7:0]  m_pit;

    beat_t       expected_beats [$];
    int          error_count;
    int          cycle_count;
    logic        hold_req;      // The test asks the receiver for a long hold-off.
    logic        hold_off;      // The receiver refuses all beats while set.
    logic        stall_enable;  // Random receiver stalls are allowed while set.
    logic [31:0] clock_us;      // Running time used for polls.
    int          stall_left;

    vtx_serial_link_controller i_dut (.*);

    initial clk = 1'b0;
    always #4 clk = ~clk;

    // Global watchdog on the cycle count.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("ERROR @%0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
        error_count++;
    endtask

    // ------------------------------------------------------------------
    // Predictor.
    // ------------------------------------------------------------------
    function automatic logic [7:0] byte_sum(input logic [7:0] f [16]);
        logic [7:0] s;
        s = 8'd0;
        for (int k = 1; k < 14; k++)
            s += f[k];
        return s;
    endfunction

    function automatic logic [15:0] frame_word(input int k);
        return {m_frame[(k + 1) & 15], m_frame[k & 15]};
    endfunction

    function automatic beat_t status_beat(input logic accepted);
        beat_t b;
        b = '0;
        b.link_state = m_link;
        b.commit_accepted = accepted;
        b.cur_freq = m_status[0];
        b.cur_config_power = m_status[1];
        b.cur_power = m_status[2];
        b.pit_state = m_pit;
        b.freq_min = m_range[0];
        b.freq_max = m_range[1];
        b.power_max = m_range[2];
        return b;
    endfunction

    task automatic push_idle(input logic accepted);
        beat_t b;
        b = status_beat(accepted);
        b.tx_last = 1'b1;
        expected_beats.push_back(b);
    endtask

    task automatic push_frame(input logic [7:0] code, input logic [15:0] param);
        logic [7:0] f [16];
        beat_t b;
        for (int k = 0; k < 16; k++)
            f[k] = 8'd0;
        f[0] = LEN_BYTE;
        f[1] = code;
        f[2] = param[7:0];
        f[3] = param[15:8];
        f[14] = byte_sum(f);
        for (int k = 0; k < 16; k++)
        begin
            b = status_beat(1'b0);
            b.has_tx = 1'b1;
            b.tx_byte = f[k];
            b.tx_last = (k == 15);
            expected_beats.push_back(b);
        end
    endtask

    function automatic logic interval_passed(input logic [31:0] now,
                                             input logic [30:0] ivl);
        logic [31:0] d;
        d = now - m_last_query;
        return !d[31] && d > {1'b0, ivl};
    endfunction

    task automatic deframe(input logic [7:0] c);
        m_frame[m_pos[3:0]] = c;
        m_pos = m_pos + 5'd1;
        case (m_parse)
            PH_LEN:
            begin
                if (c == LEN_BYTE) m_parse = PH_CODE;
                else m_pos = 5'd0;
            end
            PH_CODE:
            begin
                if (c == CODE_R || c == CODE_V || c == CODE_S) m_parse = PH_DATA;
                else
                begin
                    m_parse = PH_LEN;
                    m_pos = 5'd0;
                end
            end
            PH_DATA:
            begin
                if (m_pos >= 5'd16)
                begin
                    m_parse = PH_LEN;
                    m_pos = 5'd0;
                    if (m_frame[14] == byte_sum(m_frame) && m_frame[15] == 8'd0)
                    begin
                        if (m_frame[1] == CODE_R && frame_word(2) != 16'd0)
                        begin
                            m_range[0] = frame_word(2);
                            m_range[1] = frame_word(4);
                            m_range[2] = frame_word(6);
                            m_pend = PEND_R;
                        end
                        else if (m_frame[1] == CODE_V && frame_word(2) != 16'd0)
                        begin
                            m_status[0] = frame_word(2);
                            m_status[1] = frame_word(4);
                            m_pit = m_frame[7];
                            m_status[2] = frame_word(8);
                            m_pend = PEND_V;
                        end
                    end
                end
            end
            default:
            begin
                m_parse = PH_LEN;
                m_pos = 5'd0;
            end
        endcase
    endtask

    task automatic predict_poll(input logic [31:0] now);
        if (m_pend == PEND_R && m_link == LINK_OFF) m_link = LINK_ON;
        else if (m_pend == PEND_V && m_link == LINK_CHECK) m_link = LINK_SET;
        m_pend = PEND_NONE;
        case (m_link)
            LINK_OFF, LINK_ON:
            begin
                if (interval_passed(now, m_query_ivl))
                begin
                    m_last_query = now;
                    m_parse = PH_LEN;
                    m_pos = 5'd0;
                    push_frame(m_link == LINK_OFF ? CODE_R : CODE_V, 16'd0);
                    return;
                end
            end
            LINK_SET:
            begin
                if (m_target_freq != m_status[0] || m_target_power != m_status[1])
                begin
                    m_link = LINK_CHECK;
                    m_last_query = now + {1'b0, m_settle_dly};
                    if (m_target_freq != m_status[0]) push_frame(CODE_F, m_target_freq);
                    else push_frame(CODE_P, m_target_power);
                    return;
                end
                m_link = LINK_ON;
            end
            default:
            begin
                if (interval_passed(now, m_recheck_ivl))
                begin
                    m_last_query = now;
                    m_parse = PH_LEN;
                    m_pos = 5'd0;
                    push_frame(CODE_V, 16'd0);
                    return;
                end
            end
        endcase
        push_idle(1'b0);
    endtask

    task automatic predict_item(input cmd_t cmd, input logic [7:0] b,
                                input logic [31:0] now, input logic pit);
        case (cmd)
            CMD_RX:
            begin
                deframe(b);
                push_idle(1'b0);
            end
            CMD_POLL: predict_poll(now);
            CMD_COMMIT:
            begin
                if (m_link == LINK_ON)
                begin
                    m_link = LINK_SET;
                    push_idle(1'b1);
                end
                else
                    push_idle(1'b0);
            end
            default: push_frame(CODE_I, pit ? 16'd0 : 16'd1);
        endcase
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------
    function automatic int random_gap();
        if ($urandom_range(0, 3) == 0) return 0;
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
        return $urandom_range(0, 3);
    endfunction

    // Sends one item; the prediction is made at the accepting edge. Valid stays
    // high after the accepting edge until the next item or an idle gap begins.
    task automatic send_item(input cmd_t cmd, input logic [7:0] b,
                             input logic [31:0] now, input logic pit);
        int gap;
        gap = random_gap();
        @(negedge clk);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        command <= cmd;
        rx_byte <= b;
        now_us <= now;
        pit_on <= pit;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        predict_item(cmd, b, now, pit);
    endtask

    task automatic send_bytes(input logic [7:0] f [16]);
        for (int k = 0; k < 16; k++)
            send_item(CMD_RX, f[k], $urandom, 1'($urandom_range(0, 1)));
    endtask

    // Builds a well-formed reply frame with the given code and a random payload.
    task automatic build_reply(input logic [7:0] code, output logic [7:0] f [16]);
        for (int k = 0; k < 16; k++)
            f[k] = (k >= 2 && k < 14) ? 8'($urandom) : 8'd0;
        f[0] = LEN_BYTE;
        f[1] = code;
        if ($urandom_range(0, 3) == 0) f[3] = 8'd0;
        f[14] = byte_sum(f);
    endtask

    task automatic send_reply(input logic [7:0] code);
        logic [7:0] f [16];
        build_reply(code, f);
        send_bytes(f);
    endtask

    // Polls with time advanced by the given step.
    task automatic poll_after(input logic [31:0] step);
        clock_us = clock_us + step;
        send_item(CMD_POLL, 8'($urandom), clock_us, 1'($urandom_range(0, 1)));
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_beats.size() != 0) @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_register(input reg_idx_t idx, input logic [31:0] value);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 5'(idx) << 2;
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        case (idx)
            REG_TARGET_FREQ: m_target_freq = value[15:0];
            REG_TARGET_POWER: m_target_power = value[15:0];
            REG_QUERY_IVL: m_query_ivl = value[30:0];
            REG_RECHECK_IVL: m_recheck_ivl = value[30:0];
            default: m_settle_dly = value[30:0];
        endcase
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------

    // Bring the link online, commit, and walk through set and recheck.
    task automatic test_directed();
        logic [7:0] f [16];
        send_item(CMD_COMMIT, 8'h00, 32'h0, 1'b0);     // commit while offline
        send_item(CMD_PIT, 8'hFF, 32'hFFFF_FFFF, 1'b1);
        send_item(CMD_PIT, 8'h00, 32'h0, 1'b0);
        poll_after(32'd2_000_000);                      // range query
        send_reply(CODE_S);                             // dropped code
        build_reply(CODE_R, f);
        f[2] = 8'd0;
        f[3] = 8'd0;
        f[14] = byte_sum(f);
        send_bytes(f);                                  // zero range, dropped
        build_reply(CODE_R, f);
        f[2] = 8'hFF;
        f[15] = 8'h01;                                  // bad trailer
        send_bytes(f);
        send_reply(CODE_R);
        send_reply(CODE_V);                             // latch keeps the last
        poll_after(32'd10);
        send_reply(CODE_R);
        poll_after(32'd10);                             // online now
        send_item(CMD_COMMIT, 8'h00, 32'h0, 1'b1);
        poll_after(32'd10);                             // set frame
        send_reply(CODE_V);
        poll_after(32'h7FFF_FFFF);                      // just under half range
        poll_after(32'd1_000_000);
    endtask

    task automatic test_random(input int items);
        int sent;
        int pick;
        sent = 0;
        while (sent < items)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
            begin
                send_reply($urandom_range(0, 1) ? CODE_R : CODE_V);
                sent += 16;
            end
            else if (pick < 65)
            begin
                clock_us = clock_us + ($urandom_range(0, 1) ? $urandom_range(0, 400000)
                                                            : $urandom);
                send_item(CMD_POLL, 8'($urandom), clock_us, 1'($urandom_range(0, 1)));
                sent++;
            end
            else if (pick < 75)
            begin
                send_item(CMD_COMMIT, 8'($urandom), $urandom, 1'($urandom_range(0, 1)));
                sent++;
            end
            else if (pick < 82)
            begin
                send_item(CMD_PIT, 8'($urandom), $urandom, 1'($urandom_range(0, 1)));
                sent++;
            end
            else
            begin
                // Noise, including a truncated or corrupted frame start.
                if ($urandom_range(0, 1)) send_item(CMD_RX, LEN_BYTE, $urandom, 1'b0);
                send_item(CMD_RX, 8'($urandom), $urandom, 1'($urandom_range(0, 1)));
                sent++;
            end
        end
    endtask

    // The receiver holds off while the sender keeps offering frame-sized work,
    // so the queue fills and the input stalls until the hold-off runs out.
    task automatic test_backpressure();
        hold_req = 1'b1;
        wait (hold_off);
        hold_req = 1'b0;
        for (int k = 0; k < 8; k++)
            send_item(CMD_PIT, 8'($urandom), $urandom, 1'($urandom_range(0, 1)));
        wait_drained();
    endtask

    task automatic test_config(input int phase);
        case (phase)
            0:
            begin
                write_register(REG_TARGET_FREQ, 32'h0000_FFFF);
                write_register(REG_TARGET_POWER, 32'h0000_0000);
                write_register(REG_QUERY_IVL, 32'h7FFF_FFFF);
                write_register(REG_RECHECK_IVL, 32'h0000_0000);
                write_register(REG_SETTLE_DLY, 32'h7FFF_FFFF);
            end
            1:
            begin
                write_register(REG_TARGET_FREQ, 32'h0);
                write_register(REG_TARGET_POWER, 32'hFFFF);
                write_register(REG_QUERY_IVL, 32'h0);
                write_register(REG_RECHECK_IVL, 32'h7FFF_FFFF);
                write_register(REG_SETTLE_DLY, 32'h0);
            end
            default:
            begin
                write_register(REG_TARGET_FREQ, $urandom);
                write_register(REG_TARGET_POWER, $urandom);
                write_register(REG_QUERY_IVL, $urandom_range(0, 500000));
                write_register(REG_RECHECK_IVL, $urandom_range(0, 300000));
                write_register(REG_SETTLE_DLY, $urandom_range(0, 300000));
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stalls, mostly short with a few long ones, or a long
    // hold-off counted here in cycles.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall_left <= 0;
        end
        else if (hold_off)
            out_ready <= 1'b0;
        else if (!stall_enable)
            out_ready <= 1'b1;
        else if (stall_left != 0)
        begin
            out_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if ($urandom_range(0, 49) == 0)
        begin
            out_ready <= 1'b0;
            stall_left <= $urandom_range(10, 40);
        end
        else
            out_ready <= ($urandom_range(0, 3) != 0);
    end

    int hold_cycles;
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            hold_off <= 1'b0;
            hold_cycles <= 0;
        end
        else if (hold_off)
        begin
            hold_cycles <= hold_cycles + 1;
            if (hold_cycles >= HOLD_CYCLES - 1)
                hold_off <= 1'b0;
        end
        else if (hold_req)
        begin
            hold_off <= 1'b1;
            hold_cycles <= 0;
        end
    end

    // Checker: compares every accepted beat with the oldest expectation.
    always @(posedge clk)
    begin
        beat_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_beats.size() == 0)
                report_mismatch("unexpected beat", tx_byte, 32'h0);
            else
            begin
                want = expected_beats.pop_front();
                if (has_tx !== want.has_tx) report_mismatch("has_tx", has_tx, want.has_tx);
                if (tx_byte !== want.tx_byte)
                    report_mismatch("tx_byte", tx_byte, want.tx_byte);
                if (tx_last !== want.tx_last)
                    report_mismatch("tx_last", tx_last, want.tx_last);
                if (link_state !== want.link_state)
                    report_mismatch("link_state", link_state, want.link_state);
                if (commit_accepted !== want.commit_accepted)
                    report_mismatch("commit_accepted", commit_accepted,
                                    want.commit_accepted);
                if (cur_freq !== want.cur_freq)
                    report_mismatch("cur_freq", cur_freq, want.cur_freq);
                if (cur_config_power !== want.cur_config_power)
                    report_mismatch("cur_config_power", cur_config_power,
                                    want.cur_config_power);
                if (cur_power !== want.cur_power)
                    report_mismatch("cur_power", cur_power, want.cur_power);
                if (pit_state !== want.pit_state)
                    report_mismatch("pit_state", pit_state, want.pit_state);
                if (freq_min !== want.freq_min)
                    report_mismatch("freq_min", freq_min, want.freq_min);
                if (freq_max !== want.freq_max)
                    report_mismatch("freq_max", freq_max, want.freq_max);
                if (power_max !== want.power_max)
                    report_mismatch("power_max", power_max, want.power_max);
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------
    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        command = CMD_RX;
        rx_byte = 8'd0;
        now_us = 32'd0;
        pit_on = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = 5'd0;
        pwdata = 32'd0;
        hold_req = 1'b0;
        stall_enable = 1'b0;
        error_count = 0;
        clock_us = 32'd0;
        // Predictor reset state.
        m_target_freq = 16'd0;
        m_target_power = 16'd0;
        m_query_ivl = QUERY_DEFAULT;
        m_recheck_ivl = RECHECK_DEFAULT;
        m_settle_dly = SETTLE_DEFAULT;
        m_parse = PH_LEN;
        m_pos = 5'd0;
        for (int k = 0; k < 16; k++)
            m_frame[k] = 8'd0;
        m_link = LINK_OFF;
        m_pend = PEND_NONE;
        m_last_query = 32'd0;
        for (int k = 0; k < 3; k++)
        begin
            m_range[k] = 16'd0;
            m_status[k] = 16'd0;
        end
        m_pit = 8'd0;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // First pass runs at the reset configuration with no receiver stalls.
        test_directed();
        wait_drained();
        stall_enable = 1'b1;
        test_backpressure();
        for (int phase = 0; phase < 3; phase++)
        begin
            test_config(phase);
            test_random(110);
            // The sender pauses until every expected beat has arrived.
            wait_drained();
        end

        repeat (20) @(posedge clk);
        if (error_count == 0 && expected_beats.size() == 0)
            $display("*** PASSED ***");
        else
        begin
            if (expected_beats.size() != 0)
                $display("ERROR: %0d expected beats never arrived", expected_beats.size());
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
